FILE: sv/rbf_svm_decision_score_unit_assert.svh
// assertion macros for the rbf svm score unit
`ifndef RBF_SVM_DECISION_SCORE_UNIT_ASSERT_SVH
`define RBF_SVM_DECISION_SCORE_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define RSVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define RSVM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: sv/rsvm_pkg.sv
// shared types, constants and the exp2 fraction table
`timescale 1ns / 1ps
package rsvm_pkg;
    localparam int MAX_VECTORS = 256;
    localparam int FEATURES    = 8;
    localparam int SLOT_W      = $clog2(MAX_VECTORS);
    localparam int CNT_W       = $clog2(MAX_VECTORS + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] STEP_Q32 = 64'd4283353945;

    typedef struct packed {
        logic               op;
        logic [7:0]         slot;
        logic signed [31:0] weight;
        logic signed [15:0] feature_7;
        logic signed [15:0] feature_6;
        logic signed [15:0] feature_5;
        logic signed [15:0] feature_4;
        logic signed [15:0] feature_3;
        logic signed [15:0] feature_2;
        logic signed [15:0] feature_1;
        logic signed [15:0] feature_0;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] score;
        logic               saturated;
    } t_out_item;

    typedef logic signed [15:0] t_vec [FEATURES];

    // control from the sequencer to the kernel pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_lane_ctl;

    // 65536 * 2^(-f/256) by repeated rounded steps
    function automatic logic [15:0] pow2_frac(input logic [7:0] f);
        logic [63:0] x;
        logic [63:0] e;
        x = 64'd1 << 32;
        for (int k = 0; k < 256; k++) begin
            if (k == int'(f)) begin
                e = (x + 64'd32768) >> 16;
                return (e > 64'd65535) ? 16'hFFFF : e[15:0];
            end
            x = ((x * STEP_Q32) + (64'd1 << 31)) >> 32;
        end
        return 16'd0;
    endfunction

    typedef logic [15:0] t_table [256];
    function automatic t_table build_table();
        t_table t;
        for (int i = 0; i < 256; i++) t[i] = pow2_frac(8'(i));
        return t;
    endfunction
    localparam t_table POW2_TABLE = build_table();
endpackage

FILE: sv/rsvm_lanes.sv
// eight difference-square lanes and the adder tree that merges them
`timescale 1ns / 1ps
module rsvm_lanes (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rsvm_pkg::t_lane_ctl        i_ctl,
    input  logic [16*rsvm_pkg::FEATURES-1:0] i_x,
    input  logic [16*rsvm_pkg::FEATURES-1:0] i_sv,
    output rsvm_pkg::t_lane_ctl        o_ctl,
    output logic [36:0]                o_d2
);
    logic [33:0] r_sq [rsvm_pkg::FEATURES];
    logic [34:0] r_s1 [4];
    logic [36:0] r_d2;
    rsvm_pkg::t_lane_ctl r_c0, r_c1, r_c2;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < rsvm_pkg::FEATURES; j++) begin
            logic signed [16:0] d;
            d = 17'(signed'(i_x[16*j +: 16])) - 17'(signed'(i_sv[16*j +: 16]));
            r_sq[j] <= unsigned'(34'(d) * 34'(d));
        end
        for (int k = 0; k < 4; k++) r_s1[k] <= {1'b0, r_sq[2*k]} + {1'b0, r_sq[2*k+1]};
        r_d2 <= {2'b0, r_s1[0]} + {2'b0, r_s1[1]} + {2'b0, r_s1[2]} + {2'b0, r_s1[3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
            r_c2 <= '0;
        end else begin
            r_c0 <= i_ctl;
            r_c1 <= r_c0;
            r_c2 <= r_c1;
        end
    end
    assign o_ctl = r_c2;
    assign o_d2  = r_d2;
endmodule

FILE: sv/rsvm_kernel_acc.sv
// exp kernel, weighting and accumulation with final rounding
`timescale 1ns / 1ps
module rsvm_kernel_acc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsvm_pkg::t_lane_ctl i_ctl,
    input  logic [36:0]         i_d2,
    input  logic [15:0]         i_gamma,
    input  logic signed [31:0]  i_weight,
    input  logic signed [31:0]  i_offset_b,
    input  logic                i_start,
    output logic                o_done,
    output rsvm_pkg::t_out_item o_res
);
    // stage a: t = gamma*d2 (>= 2^34 means kernel zero)
    logic [52:0] n_t;
    logic [19:0] r_t16;
    logic        r_tz;
    logic        r_tz_b;
    logic signed [31:0] r_wa, r_wb, r_wc;
    rsvm_pkg::t_lane_ctl r_ca, r_cb, r_cc;
    logic [36:0] r_u;
    logic [7:0]  w_f;
    logic [15:0] r_k;
    logic signed [63:0] r_acc;
    logic        r_done;
    logic signed [63:0] n_acc_add;
    logic signed [48:0] n_prod;

    assign n_t = 53'(i_d2) * 53'(i_gamma);
    // u is the product over 2^16: integer part from bit 32, table index at bits 31:24
    assign w_f = r_u[31:24];

    always_ff @(posedge i_clk) begin
        r_tz   <= n_t >= (53'd16 << 30);
        r_t16  <= n_t[33:14];
        r_wa   <= i_weight;
        r_u    <= 37'(r_t16) * 37'(rsvm_pkg::LOG2E_Q16);
        // zero flag is registered again so it stays aligned with r_u, behind r_t16
        r_tz_b <= r_tz;
        r_wb   <= r_wa;
        if (r_tz_b || r_u[36:32] >= 5'd16) r_k <= 16'd0;
        else r_k <= rsvm_pkg::POW2_TABLE[w_f] >> r_u[35:32];
        r_wc   <= r_wb;
    end

    assign n_prod = 49'(r_wc) * $signed({1'b0, r_k});
    assign n_acc_add = r_acc + 64'(n_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= '0; r_cb <= '0; r_cc <= '0; r_done <= 1'b0;
            r_acc <= '0;
        end else begin
            r_ca <= i_ctl; r_cb <= r_ca; r_cc <= r_cb;
            r_done <= 1'b0;
            if (i_start) r_acc <= -(64'(i_offset_b) <<< 16);
            else if (r_cc.valid) begin
                r_acc <= n_acc_add;
                if (r_cc.last) r_done <= 1'b1;
            end
        end
    end

    // the sum stays far inside the 48 bit score range, so it never clips
    always_comb begin
        logic signed [63:0] r;
        logic signed [47:0] q;
        r = r_acc + 64'sd32768;
        q = r[63:16];
        o_res.score = q;
        o_res.saturated = 1'b0;
    end
    assign o_done = r_done;
endmodule

FILE: sv/rbf_svm_decision_score_unit.sv
// Each score item walks the first vectors_in_use support vectors, one per cycle, with
// eight difference lanes merged by an adder tree, then the exp2 table and the weighted
// accumulator. The input is ready again in the cycle the result is registered; the
// walk rate is set by the single read port of the vector store. A registered output
// lets loads and the next score go on while a result waits. A load gives no result.
// With no vectors the score is round(-offset_b). The store needs no clearing after
// reset.
`timescale 1ns / 1ps
module rbf_svm_decision_score_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rsvm_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rsvm_pkg::t_out_item  o_data,
    input  logic                 i_cfg_we,
    input  logic [rsvm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsvm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0, S_WALK = 2'd1, S_WAIT = 2'd2, S_DONE = 2'd3;

    logic [1:0]  r_state;
    logic [15:0] r_gamma;
    logic signed [31:0] r_offset;
    logic [rsvm_pkg::CNT_W-1:0] r_count, r_idx;
    logic [16*rsvm_pkg::FEATURES-1:0] r_x, r_sv_rd;
    logic signed [31:0] r_w_rd;
    logic [16*rsvm_pkg::FEATURES-1:0] r_vec_mem [rsvm_pkg::MAX_VECTORS];
    logic [31:0] r_w_mem [rsvm_pkg::MAX_VECTORS];
    logic [31:0] r_wp [3];
    rsvm_pkg::t_lane_ctl r_rd_ctl, w_lane_ctl;
    logic [36:0] w_d2;
    logic w_done, r_start, r_o_valid;
    rsvm_pkg::t_out_item w_res, r_out;
    logic [rsvm_pkg::CNT_W-1:0] w_eff;
    logic w_acc;
    logic w_load;

    assign w_acc = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign w_eff = (r_count > rsvm_pkg::CNT_W'(rsvm_pkg::MAX_VECTORS)) ?
                   rsvm_pkg::CNT_W'(rsvm_pkg::MAX_VECTORS) : r_count;
    // finished score moves to the output register once it is free
    assign w_load = (r_state == S_DONE) && (!r_o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (w_acc && i_data.op == rsvm_pkg::OP_LOAD) begin
            r_vec_mem[i_data.slot] <= i_data[16*rsvm_pkg::FEATURES-1:0];
            r_w_mem[i_data.slot]   <= i_data.weight;
        end
        r_sv_rd <= r_vec_mem[r_idx[rsvm_pkg::SLOT_W-1:0]];
        r_w_rd  <= r_w_mem[r_idx[rsvm_pkg::SLOT_W-1:0]];
        r_wp[0] <= r_w_rd; r_wp[1] <= r_wp[0]; r_wp[2] <= r_wp[1];
        if (w_acc) r_x <= i_data[16*rsvm_pkg::FEATURES-1:0];
        if (w_load) r_out <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_idx <= '0; r_rd_ctl <= '0;
            r_start <= 1'b0; r_o_valid <= 1'b0;
            r_gamma <= 16'd256; r_offset <= '0; r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    rsvm_pkg::CFG_GAMMA:  r_gamma  <= i_cfg_data[15:0];
                    rsvm_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                    rsvm_pkg::CFG_COUNT:  r_count  <= i_cfg_data[rsvm_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            r_start <= 1'b0;
            r_rd_ctl <= '0;
            if (w_load) r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_acc && i_data.op == rsvm_pkg::OP_SCORE) begin
                    r_start <= 1'b1; r_idx <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_idx >= w_eff) begin
                        r_state <= (w_eff == '0) ? S_DONE : S_WAIT;
                    end else begin
                        r_rd_ctl.valid <= 1'b1;
                        r_rd_ctl.last <= (r_idx + 1'b1) == w_eff;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_WAIT: if (w_done) r_state <= S_DONE;
                S_DONE: if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    rsvm_lanes u_lanes (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(r_rd_ctl), .i_x(r_x), .i_sv(r_sv_rd),
        .o_ctl(w_lane_ctl), .o_d2(w_d2)
    );

    rsvm_kernel_acc u_kacc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_lane_ctl), .i_d2(w_d2),
        .i_gamma(r_gamma), .i_weight(r_wp[2]), .i_offset_b(r_offset),
        .i_start(r_start), .o_done(w_done), .o_res(w_res)
    );

    assign o_valid = r_o_valid;
    assign o_data  = r_out;
endmodule

FILE: sv/rsvm_checker.sv
// port-level checker for the score unit, bound to the top level
`timescale 1ns / 1ps
`include "rbf_svm_decision_score_unit_assert.svh"
module rsvm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input rsvm_pkg::t_in_item i_data,
    input logic o_valid,
    input logic i_ready,
    input rsvm_pkg::t_out_item o_data
);
    `RSVM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `RSVM_ASSERT_IMP(a_out_known, i_clk, i_rst_n, o_valid, !$isunknown(o_data))
    `RSVM_ASSERT_NXT(a_load_ready, i_clk, i_rst_n, i_valid && o_ready && i_data.op == rsvm_pkg::OP_LOAD, o_ready)
    `RSVM_ASSERT_NXT(a_score_busy, i_clk, i_rst_n, i_valid && o_ready && i_data.op == rsvm_pkg::OP_SCORE, !o_ready)
endmodule
bind rbf_svm_decision_score_unit rsvm_checker u_chk (.*);
